[hdl/tgcg_pkg.sv]
// Shared constants, font table, column type and row-doubling helpers of the glyph column generator.
package tgcg_pkg;

  localparam int DISPLAY_COLUMNS_DEFAULT = 128;

  localparam logic [7:0] GLYPH_FIRST    = 8'h20;
  localparam logic [7:0] GLYPH_LAST     = 8'h7E;
  localparam logic [6:0] GLYPH_FALLBACK = 7'h1F;
  localparam int         GLYPH_COUNT    = 'h5F;

  localparam logic [1:0] LARGE_PAGE_MAX = 2'd2;
  localparam logic [4:0] LIMIT_MAX      = 5'd31;
  localparam logic [2:0] SMALL_LAST_COL = 3'd5;
  localparam logic [2:0] LARGE_LAST_COL = 3'd7;

  typedef struct packed {
    logic [7:0] top;
    logic [7:0] bottom;
    logic       last;
  } col_t;

  // Each entry holds columns 0 to 4 from the most significant byte down.
  localparam logic [39:0] GLYPH_ROM [0:GLYPH_COUNT-1] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00,
    40'h14_7F_14_7F_14, 40'h24_2A_7F_2A_12, 40'h23_13_08_64_62,
    40'h36_49_55_22_50, 40'h00_05_03_00_00, 40'h00_1C_22_41_00,
    40'h00_41_22_1C_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00,
    40'h20_10_08_04_02, 40'h3E_51_49_45_3E, 40'h00_42_7F_40_00,
    40'h42_61_51_49_46, 40'h21_41_45_4B_31, 40'h18_14_12_7F_10,
    40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00,
    40'h00_56_36_00_00, 40'h00_08_14_22_41, 40'h14_14_14_14_14,
    40'h41_22_14_08_00, 40'h02_01_51_09_06, 40'h32_49_79_41_3E,
    40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_01_01,
    40'h3E_41_41_49_7A, 40'h7F_08_08_08_7F, 40'h00_41_7F_41_00,
    40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40,
    40'h7F_02_04_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46,
    40'h46_49_49_49_31, 40'h01_01_7F_01_01, 40'h3F_40_40_40_3F,
    40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F, 40'h63_14_08_14_63,
    40'h03_04_78_04_03, 40'h61_51_49_45_43, 40'h00_00_7F_41_41,
    40'h02_04_08_10_20, 40'h41_41_7F_00_00, 40'h04_02_01_02_04,
    40'h40_40_40_40_40, 40'h00_01_02_04_00, 40'h20_54_54_54_78,
    40'h7F_48_44_44_38, 40'h38_44_44_44_20, 40'h38_44_44_48_7F,
    40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h08_14_54_54_3C,
    40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00,
    40'h00_7F_10_28_44, 40'h00_41_7F_40_00, 40'h7C_04_18_04_78,
    40'h7C_08_04_04_78, 40'h38_44_44_44_38, 40'h7C_14_14_14_08,
    40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3F_44_40_20, 40'h3C_40_40_40_7C, 40'h1C_20_40_20_1C,
    40'h3C_40_30_40_3C, 40'h44_28_10_28_44, 40'h0C_50_50_50_3C,
    40'h44_64_54_4C_44, 40'h00_08_36_41_00, 40'h00_00_7F_00_00,
    40'h00_41_36_08_00, 40'h08_08_2A_1C_08
  };

  function automatic logic [7:0] double_rows4(input logic [3:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r[2*i]   = b[i];
      r[2*i+1] = b[i];
    end
    return r;
  endfunction

  function automatic logic [7:0] double_rows3(input logic [2:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      r[2*i]   = b[i];
      r[2*i+1] = b[i];
    end
    return r;
  endfunction

endpackage

[hdl/tgcg_colgen.sv]
// Column selector that turns a held glyph and a column number into one output column.
module tgcg_colgen (
  input  logic [39:0]    glyph,
  input  logic           wide,
  input  logic [2:0]     col,
  output tgcg_pkg::col_t res
);

  logic [7:0] src;

  always_comb begin
    src = 8'h00;
    if (wide) begin
      case (col)
        3'd0:    src = glyph[39:32];
        3'd1:    src = glyph[31:24];
        3'd2:    src = glyph[23:16];
        3'd3:    src = glyph[23:16];
        3'd4:    src = glyph[15:8];
        3'd5:    src = glyph[7:0];
        default: src = 8'h00;
      endcase
    end else begin
      case (col)
        3'd0:    src = glyph[39:32];
        3'd1:    src = glyph[31:24];
        3'd2:    src = glyph[23:16];
        3'd3:    src = glyph[15:8];
        3'd4:    src = glyph[7:0];
        default: src = 8'h00;
      endcase
    end
  end

  always_comb begin
    if (wide) begin
      res.top    = tgcg_pkg::double_rows4(src[3:0]);
      res.bottom = tgcg_pkg::double_rows3(src[6:4]);
      res.last   = (col == tgcg_pkg::LARGE_LAST_COL);
    end else begin
      res.top    = src;
      res.bottom = 8'h00;
      res.last   = (col == tgcg_pkg::SMALL_LAST_COL);
    end
  end

endmodule

[hdl/text_glyph_column_generator_unit.sv]
// Top level of the glyph column generator: string state, glyph register and output register.
// Each accepted character gives six columns in small mode and eight in large mode, one column
// per cycle unless the consumer stalls; the column counter over the glyph register counts them
// out, and the next character is taken in the cycle its last column moves into the output
// register. A character that gives no columns (string rejected, limit reached, no string
// started) leaves the block idle for the next character. Output columns wait in their own
// register; while the consumer stalls, the waiting column stays there and the generator pauses.
module text_glyph_column_generator_unit #(
  parameter int DISPLAY_COLUMNS = tgcg_pkg::DISPLAY_COLUMNS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       first_of_string,
  input  logic [6:0] start_col,
  input  logic [1:0] page_row,
  input  logic       mode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] byte_index,
  output logic [7:0] top_byte,
  output logic [7:0] bottom_byte,
  output logic       last
);

  localparam int DcW = $clog2(DISPLAY_COLUMNS + 1);
  localparam logic [4:0] SMALL_LIMIT =
    (DISPLAY_COLUMNS / 6 > 31) ? 5'd31 : 5'(DISPLAY_COLUMNS / 6);

  logic [4:0] chars_done;
  logic [4:0] char_limit;
  logic       held_mode;
  logic       string_rejected;

  logic        busy;
  logic [39:0] glyph;
  logic        wmode;
  logic [6:0]  base;
  logic [2:0]  col;

  logic [4:0]     eff_done;
  logic [4:0]     eff_limit;
  logic           eff_mode;
  logic           eff_rej;
  logic [4:0]     large_limit;
  logic [DcW-1:0] diff;
  logic [DcW-1:0] quot;
  logic           produce;
  logic           accept;
  logic           emit;
  logic [6:0]     glyph_idx;
  logic [6:0]     base_next;
  tgcg_pkg::col_t colres;

  tgcg_colgen u_colgen (
    .glyph (glyph),
    .wide  (wmode),
    .col   (col),
    .res   (colres)
  );

  assign emit     = busy && (!out_valid || out_ready);
  assign in_ready = !busy || (emit && colres.last);
  assign accept   = in_valid && in_ready;

  always_comb begin
    diff = DcW'(DISPLAY_COLUMNS) - DcW'(start_col);
    quot = diff >> 3;
    if (DISPLAY_COLUMNS <= int'(start_col)) begin
      large_limit = 5'd0;
    end else if (quot > DcW'(tgcg_pkg::LIMIT_MAX)) begin
      large_limit = tgcg_pkg::LIMIT_MAX;
    end else begin
      large_limit = 5'(quot);
    end
  end

  always_comb begin
    if (first_of_string) begin
      eff_done  = 5'd0;
      eff_mode  = mode;
      eff_rej   = mode && (page_row > tgcg_pkg::LARGE_PAGE_MAX);
      eff_limit = mode ? large_limit : SMALL_LIMIT;
    end else begin
      eff_done  = chars_done;
      eff_mode  = held_mode;
      eff_rej   = string_rejected;
      eff_limit = char_limit;
    end
    produce = !eff_rej && (eff_done < eff_limit);
    if ((char_code < tgcg_pkg::GLYPH_FIRST) || (char_code > tgcg_pkg::GLYPH_LAST)) begin
      glyph_idx = tgcg_pkg::GLYPH_FALLBACK;
    end else begin
      glyph_idx = 7'(char_code - tgcg_pkg::GLYPH_FIRST);
    end
    if (eff_mode) begin
      base_next = 7'({eff_done, 3'b000});
    end else begin
      base_next = 7'({eff_done, 2'b00}) + 7'({eff_done, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_done      <= 5'd0;
      char_limit      <= 5'd0;
      held_mode       <= 1'b0;
      string_rejected <= 1'b0;
      busy            <= 1'b0;
      col             <= 3'd0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        chars_done      <= produce ? eff_done + 5'd1 : eff_done;
        char_limit      <= eff_limit;
        held_mode       <= eff_mode;
        string_rejected <= eff_rej;
      end
      if (accept) begin
        busy <= produce;
        col  <= 3'd0;
      end else if (emit) begin
        busy <= !colres.last;
        col  <= col + 3'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      glyph <= tgcg_pkg::GLYPH_ROM[glyph_idx];
      wmode <= eff_mode;
      base  <= base_next;
    end
    if (emit) begin
      byte_index  <= base + 7'(col);
      top_byte    <= colres.top;
      bottom_byte <= colres.bottom;
      last        <= colres.last;
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    busy && !wmode |-> col <= tgcg_pkg::SMALL_LAST_COL)
    else $error("column counter ran past the small glyph width");

  a_done_limit: assert property (@(posedge clk) disable iff (rst)
    chars_done <= char_limit)
    else $error("character count exceeds the string limit");

  a_tail_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> busy)
    else $error("non-final column shown with no glyph in progress");

endmodule
